/* src/cnms_pkg.sv */
// Shared types, constants and the direction quantizer for the Canny
// non-maximum suppression block. No dependencies.
package cnms_pkg;

   // Configuration register indexes
   localparam logic [1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_FRAME_HEIGHT = 2'd1;

   // Smallest frame dimension that still holds a 3x3 window
   localparam int unsigned MIN_DIM = 3;

   // Largest frame the line stores, counters and result fields cover
   localparam int unsigned MAX_WIDTH  = 1024;
   localparam int unsigned MAX_HEIGHT = 4096;

   // Depth of the queue between front and back
   localparam int unsigned QUEUE_DEPTH = 4;

   // Angles in half degrees
   localparam logic [9:0] ANG_FULL  = 10'd720;  // 360 degrees
   localparam logic [9:0] ANG_HALF  = 10'd360;  // 180 degrees
   localparam logic [8:0] ANG_B45   = 9'd45;    // 22.5 degrees
   localparam logic [8:0] ANG_B135  = 9'd135;   // 67.5 degrees
   localparam logic [8:0] ANG_B225  = 9'd225;   // 112.5 degrees
   localparam logic [8:0] ANG_B315  = 9'd315;   // 157.5 degrees

   typedef enum logic [1:0] {
      SEC_HORZ    = 2'd0,
      SEC_DIAG45  = 2'd1,
      SEC_VERT    = 2'd2,
      SEC_DIAG135 = 2'd3
   } sector_type;

   typedef struct packed {
      logic [7:0] magnitude;
      logic [9:0] angle_half_deg;
   } req_type;

   typedef struct packed {
      logic [7:0]  suppressed_magnitude;
      logic [11:0] out_row;
      logic [9:0]  out_col;
      logic        frame_done;
   } rsp_type;

   // One classified pixel on its way from front to back
   typedef struct packed {
      logic [7:0]  up;
      logic [7:0]  mid;
      logic [7:0]  mag;
      sector_type  sector;
      logic        emit;
      logic        border;
      logic        last;
      logic [11:0] row;
      logic [9:0]  col;
   } item_type;

   // Quantize a gradient angle to one of four directions; each boundary
   // angle belongs to the sector that starts there.
   function automatic sector_type sector_of(input logic [9:0] angle);
      logic [9:0] a1;
      logic [8:0] a2;
      sector_type s;
      a1 = (angle >= ANG_FULL) ? angle - ANG_FULL : angle;
      a2 = (a1 >= ANG_HALF) ? 9'(a1 - ANG_HALF) : a1[8:0];
      if (a2 < ANG_B45 || a2 >= ANG_B315) begin
         s = SEC_HORZ;
      end else if (a2 < ANG_B135) begin
         s = SEC_DIAG45;
      end else if (a2 < ANG_B225) begin
         s = SEC_VERT;
      end else begin
         s = SEC_DIAG135;
      end
      return s;
   endfunction

endpackage

/* src/cnms_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read.
// Read returns the old contents when read and write hit the same address.
module cnms_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/cnms_front.sv */
// Front end: accepts pixels, tracks the raster position, runs the line
// stores and classifies each pixel. Depends on cnms_pkg and cnms_ram.
module cnms_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  cnms_pkg::req_type req_data,
   input  logic [10:0]       frame_width,
   input  logic [12:0]       frame_height,
   output logic              push_valid,
   output cnms_pkg::item_type push_data
);
   import cnms_pkg::*;

   localparam int unsigned AW = $clog2(MAX_WIDTH);

   logic [9:0]    col_ff, col_in;
   logic [11:0]   row_ff, row_in;
   logic [10:0]   w_lim;
   logic [12:0]   h_lim;
   logic          last_col, last_row;
   logic [AW-1:0] addr_a;

   // stage B registers
   logic          b_valid_ff;
   logic [AW-1:0] b_addr_ff;
   logic [7:0]    b_mag_ff;
   logic          b_emit_ff, b_border_ff, b_last_ff;
   logic [11:0]   b_row_ff;
   logic [9:0]    b_col_ff;
   logic          b_fwd_ff;
   logic [7:0]    b_fwd_data_ff;

   logic [7:0]    upper_rd, middle_rd;
   logic [9:0]    angle_rd;

   // Clamp the frame dimensions
   always_comb begin
      if (32'(frame_width) < MIN_DIM) begin
         w_lim = 11'(MIN_DIM);
      end else if (32'(frame_width) > MAX_WIDTH) begin
         w_lim = 11'(MAX_WIDTH);
      end else begin
         w_lim = frame_width;
      end
      if (32'(frame_height) < MIN_DIM) begin
         h_lim = 13'(MIN_DIM);
      end else if (32'(frame_height) > MAX_HEIGHT) begin
         h_lim = 13'(MAX_HEIGHT);
      end else begin
         h_lim = frame_height;
      end
   end

   assign last_col = {1'b0, col_ff} >= (w_lim - 11'd1);
   assign last_row = {1'b0, row_ff} >= (h_lim - 13'd1);
   assign addr_a   = (32'(col_ff) < MAX_WIDTH) ? AW'(col_ff) : '0;

   // Advance the raster position, wrap at row and frame ends
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + 12'd1;
         end else begin
            col_in = col_ff + 10'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= '0;
         row_ff     <= '0;
         b_valid_ff <= 1'b0;
      end else begin
         col_ff     <= col_in;
         row_ff     <= row_in;
         b_valid_ff <= accept;
      end
   end

   // Capture the classified pixel; forward the pending upper-line write
   // when the next pixel reads the same column
   always_ff @(posedge clock) begin
      if (accept) begin
         b_addr_ff     <= addr_a;
         b_mag_ff      <= req_data.magnitude;
         b_emit_ff     <= (row_ff != '0) && (col_ff != '0);
         b_border_ff   <= (row_ff == 12'd1) || (col_ff == 10'd1);
         b_last_ff     <= last_col && last_row;
         b_row_ff      <= row_ff - 12'd1;
         b_col_ff      <= col_ff - 10'd1;
         b_fwd_ff      <= b_valid_ff && (b_addr_ff == addr_a);
         b_fwd_data_ff <= middle_rd;
      end
   end

   // Line stores: middle and angle are written on accept, upper in the next
   // cycle with the middle line's old contents
   cnms_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_upper (
      .clock   (clock),
      .wr_en   (b_valid_ff),
      .wr_addr (b_addr_ff),
      .wr_data (middle_rd),
      .rd_addr (addr_a),
      .rd_data (upper_rd)
   );

   cnms_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_middle (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (addr_a),
      .wr_data (req_data.magnitude),
      .rd_addr (addr_a),
      .rd_data (middle_rd)
   );

   cnms_ram #(.WIDTH(10), .DEPTH(MAX_WIDTH)) u_angle (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (addr_a),
      .wr_data (req_data.angle_half_deg),
      .rd_addr (addr_a),
      .rd_data (angle_rd)
   );

   // Build the queue entry
   always_comb begin
      push_data.up     = b_fwd_ff ? b_fwd_data_ff : upper_rd;
      push_data.mid    = middle_rd;
      push_data.mag    = b_mag_ff;
      push_data.sector = sector_of(angle_rd);
      push_data.emit   = b_emit_ff;
      push_data.border = b_border_ff;
      push_data.last   = b_last_ff;
      push_data.row    = b_row_ff;
      push_data.col    = b_col_ff;
   end

   assign push_valid = b_valid_ff;

endmodule

/* src/cnms_queue.sv */
// Short register FIFO between the front and the back end.
// Depends on cnms_pkg for the entry type.
module cnms_queue #(
   parameter int unsigned DEPTH = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  cnms_pkg::item_type         push_data,
   input  logic                       pop,
   output logic                       pop_valid,
   output cnms_pkg::item_type         pop_data,
   output logic [$clog2(DEPTH+1)-1:0] count
);
   import cnms_pkg::*;

   localparam int unsigned PW = $clog2(DEPTH);
   localparam int unsigned CW = $clog2(DEPTH + 1);

   item_type         entry_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0]    count_ff, count_in;

   // Track occupancy
   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= (32'(wr_ptr_ff) == DEPTH - 1) ? '0 : wr_ptr_ff + PW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (32'(rd_ptr_ff) == DEPTH - 1) ? '0 : rd_ptr_ff + PW'(1);
         end
      end
   end

   // Store entries
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_valid = (count_ff != '0);
   assign pop_data  = entry_ff[rd_ptr_ff];
   assign count     = count_ff;

endmodule

/* src/cnms_back.sv */
// Back end: slides the 3x3 window, picks the neighbour pair, decides
// suppression and holds the result register. Depends on cnms_pkg.
module cnms_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               item_valid,
   input  cnms_pkg::item_type item,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output cnms_pkg::rsp_type  rsp_data
);
   import cnms_pkg::*;

   // window columns: left (top, mid, bottom), centre (top, mid, bottom)
   logic [7:0] win_ff [6];
   sector_type centre_sec_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_data_ff;
   logic [7:0] n1, n2, centre, result;

   assign pop    = item_valid && (!rsp_valid_ff || !rsp_stall);
   assign centre = win_ff[4];

   // Select the neighbours along the quantized direction
   always_comb begin
      unique case (centre_sec_ff)
         SEC_HORZ: begin
            n1 = win_ff[1];
            n2 = item.mid;
         end
         SEC_DIAG45: begin
            n1 = item.up;
            n2 = win_ff[2];
         end
         SEC_VERT: begin
            n1 = win_ff[3];
            n2 = win_ff[5];
         end
         SEC_DIAG135: begin
            n1 = win_ff[0];
            n2 = item.mag;
         end
         default: begin
            n1 = win_ff[1];
            n2 = item.mid;
         end
      endcase
      result = (!item.border && centre > n1 && centre > n2) ? centre : 8'd0;
   end

   // Shift the window and the centre direction
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= '0;
         end
         centre_sec_ff <= SEC_HORZ;
      end else if (pop) begin
         win_ff[0]     <= win_ff[3];
         win_ff[1]     <= win_ff[4];
         win_ff[2]     <= win_ff[5];
         win_ff[3]     <= item.up;
         win_ff[4]     <= item.mid;
         win_ff[5]     <= item.mag;
         centre_sec_ff <= item.sector;
      end
   end

   // Output register: load on pop, drop after transfer, hold while stalled
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (pop) begin
         rsp_valid_in = item.emit;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_data_ff.suppressed_magnitude <= result;
         rsp_data_ff.out_row              <= item.row;
         rsp_data_ff.out_col              <= item.col;
         rsp_data_ff.frame_done           <= item.last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* src/canny_non_maximum_suppression.sv */
// Canny non-maximum suppression over a 3x3 window on a raster stream of
// gradient magnitudes and angles. Sustains one pixel per clock unless
// stalled: the front end reads and writes the three line stores once per
// pixel and a four-entry queue feeds the back end, which retires one pixel
// per clock. A pixel's result is registered after stage B and the queue;
// every pixel from row 1 and column 1 on gives one result for the centre
// one row and one column back, and border centres give zero. Frames up to
// 1024 by 4096 pixels are covered. The line stores start undefined and
// need no clearing pass. Write frame_width and frame_height only while idle.
// Depends on cnms_pkg, cnms_front, cnms_queue and cnms_back.
module canny_non_maximum_suppression (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  cnms_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output cnms_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [12:0]       csr_data
);
   import cnms_pkg::*;

   localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

   logic [10:0] frame_width_ff;
   logic [12:0] frame_height_ff;
   logic        accept;
   logic        push_valid, pop, pop_valid;
   item_type    push_data, pop_data;
   logic [CW-1:0] count;

   // Configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= 11'd640;
         frame_height_ff <= 13'd480;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH:  frame_width_ff  <= csr_data[10:0];
            CSR_FRAME_HEIGHT: frame_height_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Stall input while the queue could not take the pixels in flight
   assign req_stall = (32'(count) + 32'(push_valid)) >= QUEUE_DEPTH;
   assign accept    = req_valid && !req_stall;

   cnms_front u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .req_data     (req_data),
      .frame_width  (frame_width_ff),
      .frame_height (frame_height_ff),
      .push_valid   (push_valid),
      .push_data    (push_data)
   );

   cnms_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push_valid),
      .push_data (push_data),
      .pop       (pop),
      .pop_valid (pop_valid),
      .pop_data  (pop_data),
      .count     (count)
   );

   cnms_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (pop_valid),
      .item       (pop_data),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

/* src/cnms_checker.sv */
// Port-level checks for canny_non_maximum_suppression, bound to the top level.
// Depends on cnms_pkg.
module cnms_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input cnms_pkg::rsp_type rsp_data
);

   // A stalled result holds until its transfer
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // Reset leaves no result pending
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // Border centres are always suppressed
   a_border_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.out_row == '0 || rsp_data.out_col == '0)
      |-> rsp_data.suppressed_magnitude == '0)
      else $error("border centre not suppressed");

   // The frame's last result never sits on a border centre
   a_done_inside: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.frame_done
      |-> rsp_data.out_row != '0 && rsp_data.out_col != '0)
      else $error("frame end flagged on a border centre");

endmodule

bind canny_non_maximum_suppression cnms_checker u_cnms_checker (.*);

/* dv/tb_canny_non_maximum_suppression.sv */
`timescale 1ns / 100ps
// Self-checking bench for canny_non_maximum_suppression: a scoreboard class
// predicts each window-centre result from accepted pixels and checks them in order.
// Depends on cnms_pkg and the block's RTL.
module tb_canny_non_maximum_suppression;
   import cnms_pkg::*;

   localparam int LINE_DEPTH      = 1024;
   localparam int TALL_LIMIT      = 4096;
   localparam int RANDOM_PIXELS   = 950;
   localparam int HOLD_OFF_CYCLES = 150;
   localparam int SETTLE_CYCLES   = 10;
   localparam int DRAIN_LIMIT     = 2000;
   localparam int MAX_REPORTS     = 10;

   // Register indexes that map to no register
   localparam logic [1:0] CSR_SPARE_A = 2'd2;
   localparam logic [1:0] CSR_SPARE_B = 2'd3;

   // Predicts suppressed centres and holds them until the block delivers them
   class nms_scoreboard;
      logic [10:0] width_reg;
      logic [12:0] height_reg;
      logic [7:0]  upper_line [LINE_DEPTH];
      logic [7:0]  middle_line [LINE_DEPTH];
      logic [9:0]  angle_line [LINE_DEPTH];
      bit          upper_known [LINE_DEPTH];
      bit          middle_known [LINE_DEPTH];
      bit          angle_known [LINE_DEPTH];
      logic [7:0]  left_col [3];
      logic [7:0]  centre_col [3];
      bit          left_known [3];
      bit          centre_known [3];
      logic [9:0]  prior_angle;
      bit          prior_known;
      logic [9:0]  col_pos;
      logic [11:0] row_pos;
      rsp_type     pending_centres [$];
      bit          pending_checked [$];
      int          pixels, results, kept, frames, reg_writes, failures, unchecked;

      function new();
         width_reg  = 11'd640;
         height_reg = 13'd480;
         foreach (upper_line[i]) begin
            upper_line[i]   = '0;
            middle_line[i]  = '0;
            angle_line[i]   = '0;
            upper_known[i]  = 1'b0;
            middle_known[i] = 1'b0;
            angle_known[i]  = 1'b0;
         end
         for (int i = 0; i < 3; i++) begin
            left_col[i]     = '0;
            centre_col[i]   = '0;
            left_known[i]   = 1'b1;
            centre_known[i] = 1'b1;
         end
         prior_angle = '0;
         prior_known = 1'b1;
         col_pos     = '0;
         row_pos     = '0;
         pixels = 0; results = 0; kept = 0; frames = 0; reg_writes = 0; failures = 0;
         unchecked = 0;
      endfunction

      function void note_failure(string msg);
         failures++;
         if (failures <= MAX_REPORTS) $display("%s", msg);
      endfunction

      function void write_reg(logic [1:0] index, logic [12:0] value);
         reg_writes++;
         case (index)
            CSR_FRAME_WIDTH:  width_reg = value[10:0];
            CSR_FRAME_HEIGHT: height_reg = value;
            default: ;
         endcase
      endfunction

      function int clamp_dim(int v, int hi);
         int d;
         d = v;
         if (d < int'(MIN_DIM)) d = int'(MIN_DIM);
         if (d > hi) d = hi;
         return d;
      endfunction

      // Fold the angle into 0..179.5 degrees, then pick the sector
      function sector_type direction_of(logic [9:0] ang);
         int d;
         sector_type s;
         d = int'(ang) % int'(ANG_HALF);
         if (d < int'(ANG_B45) || d >= int'(ANG_B315)) s = SEC_HORZ;
         else if (d < int'(ANG_B135)) s = SEC_DIAG45;
         else if (d < int'(ANG_B225)) s = SEC_VERT;
         else s = SEC_DIAG135;
         return s;
      endfunction

      function void note_pixel(req_type px);
         int w, h, c, r;
         logic [7:0] right_col [3];
         bit right_known [3];
         logic [7:0] near_a, near_b;
         logic [9:0] centre_angle;
         bit angle_ok, full_view;
         bit last_col, last_row;
         rsp_type want;
         w = clamp_dim(int'(width_reg), LINE_DEPTH);
         h = clamp_dim(int'(height_reg), TALL_LIMIT);
         c = int'(col_pos);
         r = int'(row_pos);
         last_col = (c >= w - 1);
         last_row = (r >= h - 1);
         right_col[0] = upper_line[c];
         right_col[1] = middle_line[c];
         right_col[2] = px.magnitude;
         right_known[0] = upper_known[c];
         right_known[1] = middle_known[c];
         right_known[2] = 1'b1;
         // Centre angle lags the line store read by one pixel
         centre_angle = prior_angle;
         angle_ok     = prior_known;
         prior_angle  = angle_line[c];
         prior_known  = angle_known[c];
         upper_line[c]   = middle_line[c];
         upper_known[c]  = middle_known[c];
         middle_line[c]  = px.magnitude;
         middle_known[c] = 1'b1;
         angle_line[c]   = px.angle_half_deg;
         angle_known[c]  = 1'b1;
         pixels++;

         if (r >= 1 && c >= 1) begin
            want.suppressed_magnitude = '0;
            full_view = 1'b1;
            // Border centres stay zero
            if (r >= 2 && c >= 2) begin
               // Skip the magnitude when the window holds never-written line data
               full_view = angle_ok;
               for (int i = 0; i < 3; i++)
                  full_view = full_view && left_known[i] && centre_known[i]
                              && right_known[i];
               case (direction_of(centre_angle))
                  SEC_HORZ: begin
                     near_a = left_col[1];
                     near_b = right_col[1];
                  end
                  SEC_DIAG45: begin
                     near_a = right_col[0];
                     near_b = left_col[2];
                  end
                  SEC_VERT: begin
                     near_a = centre_col[0];
                     near_b = centre_col[2];
                  end
                  default: begin
                     near_a = left_col[0];
                     near_b = right_col[2];
                  end
               endcase
               if (centre_col[1] > near_a && centre_col[1] > near_b)
                  want.suppressed_magnitude = centre_col[1];
            end
            want.out_row    = 12'(r - 1);
            want.out_col    = 10'(c - 1);
            want.frame_done = last_col && last_row;
            pending_centres.push_back(want);
            pending_checked.push_back(full_view);
         end

         // Shift the window and advance the raster position
         left_col     = centre_col;
         centre_col   = right_col;
         left_known   = centre_known;
         centre_known = right_known;
         if (last_col) begin
            col_pos = '0;
            row_pos = last_row ? '0 : row_pos + 1'b1;
         end else begin
            col_pos = col_pos + 1'b1;
         end
      endfunction

      function void check_centre(rsp_type got);
         rsp_type want;
         bit checked;
         bit bad;
         if (pending_centres.size() == 0) begin
            note_failure($sformatf("unexpected result: mag %0d row %0d col %0d done %0b",
                                   got.suppressed_magnitude, got.out_row, got.out_col,
                                   got.frame_done));
            return;
         end
         want    = pending_centres.pop_front();
         checked = pending_checked.pop_front();
         results++;
         bad = (checked && (got.suppressed_magnitude !== want.suppressed_magnitude))
               || (got.out_row !== want.out_row)
               || (got.out_col !== want.out_col)
               || (got.frame_done !== want.frame_done);
         if (bad)
            note_failure($sformatf({"mismatch: expected mag %0d row %0d col %0d done %0b,",
                                    " got mag %0d row %0d col %0d done %0b"},
                                   want.suppressed_magnitude, want.out_row, want.out_col,
                                   want.frame_done, got.suppressed_magnitude, got.out_row,
                                   got.out_col, got.frame_done));
         if (!checked) unchecked++;
         if (checked && want.suppressed_magnitude != 0) kept++;
         if (want.frame_done) frames++;
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   req_type    req_data = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   rsp_type    rsp_data;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [1:0] csr_index = CSR_FRAME_WIDTH;
   logic [12:0] csr_data = '0;
   logic       hold_off_request = 1'b0;
   int         burst_left = 0;
   nms_scoreboard board;

   canny_non_maximum_suppression dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Write one register and wait for the transfer
   task automatic write_csr(logic [1:0] index, logic [12:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      board.write_reg(index, value);
      csr_valid <= 1'b0;
   endtask

   // Offer one pixel in bursts with random gaps; hold it until the transfer
   task automatic send_pixel(req_type px);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 8));
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 32);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data  <= px;
      do @(posedge clock); while (req_stall);
      board.note_pixel(px);
   endtask

   // Stop offering, wait for every expected centre, then let the pipe settle
   task automatic drain_block();
      req_valid <= 1'b0;
      while (board.pending_centres.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_frame(logic [12:0] width_val, logic [12:0] height_val);
      drain_block();
      write_csr(CSR_FRAME_WIDTH, width_val);
      write_csr(CSR_FRAME_HEIGHT, height_val);
   endtask

   // Random pixel biased toward ties, saturated values and sector boundaries
   function automatic req_type random_pixel();
      req_type px;
      int a;
      int bounds [5] = '{0, int'(ANG_B45), int'(ANG_B135), int'(ANG_B225), int'(ANG_B315)};
      case ($urandom_range(0, 3))
         0: px.magnitude = 8'($urandom_range(0, 3));
         1: px.magnitude = 8'($urandom_range(250, 255));
         default: px.magnitude = 8'($urandom());
      endcase
      if ($urandom_range(0, 3) == 0) begin
         a = bounds[$urandom_range(0, 4)] + int'(ANG_HALF) * int'($urandom_range(0, 2))
             - int'($urandom_range(0, 1));
         if (a < 0) a = a + int'(ANG_FULL);
         if (a > 1023) a = a - int'(ANG_HALF);
      end else begin
         a = $urandom_range(0, 1023);
      end
      px.angle_half_deg = 10'(a);
      return px;
   endfunction

   // Receiver: stall in random modes, with one long hold-off on request
   initial begin
      int mode;
      int span;
      bit served;
      mode = 0;
      span = 0;
      served = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_request && !served) begin
            served = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else begin
            if (span == 0) begin
               mode = $urandom_range(0, 2);
               span = $urandom_range(16, 128);
            end
            span--;
            case (mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 3) == 0);
               default: rsp_stall <= ($urandom_range(0, 3) != 0);
            endcase
         end
      end
   end

   // Check every result transfer
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.check_centre(rsp_data);
   end

   initial begin
      int dir_mag [25] = '{ 10,  20,  30,  40,  50,
                             0, 255, 200, 200,   7,
                             9, 100, 255, 100, 255,
                            60, 200, 200, 255,   3,
                             1,   2,   3,   4, 255};
      int dir_ang [25] = '{  0, 360,  720, 1023,  44,
                           134,  45,  135,  225, 224,
                           314, 315,   44,  719, 359,
                           405, 1023, 765,  405,   0,
                           315, 675,  900, 1000,  10};
      req_type px;
      int sent, n, phase, w, h, waited;
      board = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed frame: every sector, exact boundaries, folded angles, ties
      set_frame(13'd5, 13'd5);
      for (int i = 0; i < 25; i++) begin
         px.magnitude      = 8'(dir_mag[i]);
         px.angle_half_deg = 10'(dir_ang[i]);
         send_pixel(px);
      end

      // Register extremes first, then random frame shapes
      sent = 0;
      phase = 0;
      while (sent < RANDOM_PIXELS) begin
         case (phase)
            0: begin w = 3; h = 3; end
            1: begin w = 0; h = 0; end
            2: begin w = 13'h1FFF; h = 13'h1FFF; end
            3: begin w = 1024; h = 4096; end
            default: begin
               w = ($urandom_range(0, 7) == 0) ? int'($urandom_range(13, 1024))
                                               : int'($urandom_range(3, 12));
               h = $urandom_range(3, 8);
               if ($urandom_range(0, 9) == 0) w = $urandom_range(0, 8191);
               if ($urandom_range(0, 9) == 0) h = $urandom_range(0, 8191);
            end
         endcase
         set_frame(13'(w), 13'(h));
         if ($urandom_range(0, 5) == 0)
            write_csr(($urandom_range(0, 1) == 0) ? CSR_SPARE_A : CSR_SPARE_B,
                      13'($urandom()));
         if (phase == 0) begin
            n = 150;
            hold_off_request <= 1'b1;
         end else begin
            n = $urandom_range(20, 90);
         end
         repeat (n) send_pixel(random_pixel());
         sent += n;
         phase++;
      end

      // Wait out the last results, bounded
      req_valid <= 1'b0;
      waited = 0;
      while (board.pending_centres.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (board.pending_centres.size() != 0)
         board.note_failure($sformatf("%0d expected centres never arrived",
                                      board.pending_centres.size()));

      $display("Covered %0d pixels over %0d frame shapes and %0d register writes",
               board.pixels, phase + 1, board.reg_writes);
      $display("Checked %0d centres (%0d on unwritten line data), %0d kept, %0d frames,%s",
               board.results, board.unchecked, board.kept, board.frames,
               $sformatf(" %0d failures", board.failures));
      if (board.failures == 0) begin
         $display("canny_non_maximum_suppression regression: pass");
      end else begin
         $display("canny_non_maximum_suppression regression: fail");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #2000000;
      $display("canny_non_maximum_suppression regression: fail");
      $finish;
   end

endmodule

/* files.f */
src/cnms_pkg.sv
src/cnms_ram.sv
src/cnms_front.sv
src/cnms_queue.sv
src/cnms_back.sv
src/canny_non_maximum_suppression.sv
src/cnms_checker.sv
dv/tb_canny_non_maximum_suppression.sv
